// ----- design/nv21_rotation_address_generator_assert.svh -----
// assertion macros shared by the nv21 rotation address generator modules
// expects signals clk and rst in the module that uses them
`ifndef NV21_ROTATION_ADDRESS_GENERATOR_ASSERT_SVH
`define NV21_ROTATION_ADDRESS_GENERATOR_ASSERT_SVH

// condition now implies a consequence in the same cycle
`define NV21RAG_ASSERT_IMPL(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("nv21rag same-cycle check failed");

// condition now implies a consequence in the next cycle
`define NV21RAG_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("nv21rag next-cycle check failed");

`endif

// ----- design/nv21rag_pkg.sv -----
// shared types and constants for the nv21 rotation address generator
// no dependencies
package nv21rag_pkg;

  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int STRIDE_W = 14;
  localparam int PSTR_W   = 3;
  localparam int OFF_W    = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // chroma pair stride that the block supports
  localparam logic [PSTR_W-1:0] CHROMA_PAIR_STRIDE = 3'd2;

  localparam logic [DIM_W-1:0]    RESET_DIM         = 13'd4096;
  localparam logic [STRIDE_W-1:0] RESET_ROW_STRIDE  = 14'd4096;
  localparam logic [PSTR_W-1:0]   RESET_LUMA_PSTR   = 3'd1;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROTATION      = 3'd0,
    CFG_SOURCE_WIDTH  = 3'd1,
    CFG_SOURCE_HEIGHT = 3'd2,
    CFG_LUMA_ROW      = 3'd3,
    CFG_LUMA_PIXEL    = 3'd4,
    CFG_CHROMA_ROW    = 3'd5,
    CFG_CHROMA_PIXEL  = 3'd6,
    CFG_DEST_WIDTH    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    rot_t                  rotation_quarters;
    logic [DIM_W-1:0]      source_width;
    logic [DIM_W-1:0]      source_height;
    logic [STRIDE_W-1:0]   luma_row_stride;
    logic [PSTR_W-1:0]     luma_pixel_stride;
    logic [STRIDE_W-1:0]   chroma_row_stride;
    logic [PSTR_W-1:0]     chroma_pixel_stride;
    logic [DIM_W-1:0]      dest_width;
  } cfg_t;

  // source-mapped coordinate word between the mapping and offset stages
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DIM_W-1:0]   sx;
    logic [DIM_W-1:0]   sy;
    logic               skip;
    logic               cv;
  } map_t;

  typedef struct packed {
    logic             skipped;
    logic [OFF_W-1:0] src_luma_offset;
    logic [OFF_W-1:0] dst_luma_offset;
    logic             chroma_valid;
    logic [OFF_W-1:0] src_chroma_offset;
    logic [OFF_W-1:0] dst_chroma_offset;
  } res_t;

endpackage

// ----- design/nv21rag_if.sv -----
// channel interfaces: pixel coordinate, address result and register write
// depends on nv21rag_pkg
interface nv21rag_pix_if;
  logic                             valid;
  logic                             ready;
  logic [nv21rag_pkg::COORD_W-1:0]  dest_col;
  logic [nv21rag_pkg::COORD_W-1:0]  dest_row;
  modport source (output valid, dest_col, dest_row, input ready);
  modport sink (input valid, dest_col, dest_row, output ready);
endinterface

interface nv21rag_res_if;
  logic                           valid;
  logic                           ready;
  logic                           skipped;
  logic [nv21rag_pkg::OFF_W-1:0]  src_luma_offset;
  logic [nv21rag_pkg::OFF_W-1:0]  dst_luma_offset;
  logic                           chroma_valid;
  logic [nv21rag_pkg::OFF_W-1:0]  src_chroma_offset;
  logic [nv21rag_pkg::OFF_W-1:0]  dst_chroma_offset;
  modport source (output valid, skipped, src_luma_offset, dst_luma_offset, chroma_valid,
                  src_chroma_offset, dst_chroma_offset, input ready);
  modport sink (input valid, skipped, src_luma_offset, dst_luma_offset, chroma_valid,
                src_chroma_offset, dst_chroma_offset, output ready);
endinterface

interface nv21rag_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [nv21rag_pkg::CFG_IDX_W-1:0]  index;
  logic [nv21rag_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/nv21rag_cfg_regs.sv -----
// configuration register file of the rotation address generator
// depends on nv21rag_pkg and nv21rag_cfg_if
module nv21rag_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  nv21rag_cfg_if.sink         cfg,
  output nv21rag_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rotation_quarters   <= nv21rag_pkg::ROT_0;
      regs.source_width        <= nv21rag_pkg::RESET_DIM;
      regs.source_height       <= nv21rag_pkg::RESET_DIM;
      regs.luma_row_stride     <= nv21rag_pkg::RESET_ROW_STRIDE;
      regs.luma_pixel_stride   <= nv21rag_pkg::RESET_LUMA_PSTR;
      regs.chroma_row_stride   <= nv21rag_pkg::RESET_ROW_STRIDE;
      regs.chroma_pixel_stride <= nv21rag_pkg::CHROMA_PAIR_STRIDE;
      regs.dest_width          <= nv21rag_pkg::RESET_DIM;
    end else if (cfg.valid) begin
      case (nv21rag_pkg::cfg_idx_t'(cfg.index))
        nv21rag_pkg::CFG_ROTATION: begin
          regs.rotation_quarters <= nv21rag_pkg::rot_t'(cfg.data[1:0]);
        end
        nv21rag_pkg::CFG_SOURCE_WIDTH: begin
          regs.source_width <= cfg.data[nv21rag_pkg::DIM_W-1:0];
        end
        nv21rag_pkg::CFG_SOURCE_HEIGHT: begin
          regs.source_height <= cfg.data[nv21rag_pkg::DIM_W-1:0];
        end
        nv21rag_pkg::CFG_LUMA_ROW: begin
          regs.luma_row_stride <= cfg.data[nv21rag_pkg::STRIDE_W-1:0];
        end
        nv21rag_pkg::CFG_LUMA_PIXEL: begin
          regs.luma_pixel_stride <= cfg.data[nv21rag_pkg::PSTR_W-1:0];
        end
        nv21rag_pkg::CFG_CHROMA_ROW: begin
          regs.chroma_row_stride <= cfg.data[nv21rag_pkg::STRIDE_W-1:0];
        end
        nv21rag_pkg::CFG_CHROMA_PIXEL: begin
          regs.chroma_pixel_stride <= cfg.data[nv21rag_pkg::PSTR_W-1:0];
        end
        nv21rag_pkg::CFG_DEST_WIDTH: begin
          regs.dest_width <= cfg.data[nv21rag_pkg::DIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/nv21rag_src_map.sv -----
// input register and destination-to-source coordinate mapping stage
// depends on nv21rag_pkg and nv21_rotation_address_generator_assert.svh
`include "nv21_rotation_address_generator_assert.svh"

module nv21rag_src_map #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  nv21rag_pkg::cfg_t                regs,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [nv21rag_pkg::COORD_W-1:0]  in_x,
  input  logic [nv21rag_pkg::COORD_W-1:0]  in_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output nv21rag_pkg::map_t                map
);

  logic                             v0;
  logic [nv21rag_pkg::COORD_W-1:0]  x0;
  logic [nv21rag_pkg::COORD_W-1:0]  y0;
  logic                             v1;
  logic                             ready0;
  logic                             ready1;
  logic [nv21rag_pkg::DIM_W-1:0]    eff_w;
  logic [nv21rag_pkg::DIM_W-1:0]    eff_h;
  logic signed [14:0]               sxs;
  logic signed [14:0]               sys;
  nv21rag_pkg::map_t                map_next;

  function automatic logic [nv21rag_pkg::DIM_W-1:0] eff_dim(
    input logic [nv21rag_pkg::DIM_W-1:0] d
  );
    if (d == '0) begin
      return nv21rag_pkg::DIM_W'(1);
    end else if (32'(d) > MAX_DIMENSION) begin
      return nv21rag_pkg::DIM_W'(MAX_DIMENSION);
    end else begin
      return d;
    end
  endfunction

  function automatic logic [nv21rag_pkg::DIM_W-1:0] clamp(
    input logic signed [14:0]            c,
    input logic [nv21rag_pkg::DIM_W-1:0] d
  );
    if (c < 15'sd0) begin
      return '0;
    end else if (c > $signed({2'b00, d}) - 15'sd1) begin
      return d - nv21rag_pkg::DIM_W'(1);
    end else begin
      return c[nv21rag_pkg::DIM_W-1:0];
    end
  endfunction

  assign eff_w = eff_dim(regs.source_width);
  assign eff_h = eff_dim(regs.source_height);

  assign ready1    = !v1 || out_ready;
  assign ready0    = !v0 || ready1;
  assign in_ready  = ready0;
  assign out_valid = v1;

  always_comb begin
    logic signed [14:0] xs;
    logic signed [14:0] ys;
    logic signed [14:0] ws;
    logic signed [14:0] hs;
    xs = $signed({3'b000, x0});
    ys = $signed({3'b000, y0});
    ws = $signed({2'b00, eff_w});
    hs = $signed({2'b00, eff_h});
    case (regs.rotation_quarters)
      nv21rag_pkg::ROT_90: begin
        sxs = ys;
        sys = hs - 15'sd1 - xs;
      end
      nv21rag_pkg::ROT_180: begin
        sxs = ws - 15'sd1 - xs;
        sys = hs - 15'sd1 - ys;
      end
      nv21rag_pkg::ROT_270: begin
        sxs = ws - 15'sd1 - ys;
        sys = xs;
      end
      default: begin
        sxs = xs;
        sys = ys;
      end
    endcase
    map_next.x    = x0;
    map_next.y    = y0;
    map_next.sx   = clamp(sxs, eff_w);
    map_next.sy   = clamp(sys, eff_h);
    map_next.skip = regs.chroma_pixel_stride != nv21rag_pkg::CHROMA_PAIR_STRIDE;
    map_next.cv   = !x0[0] && !y0[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (ready0) begin
        v0 <= in_valid;
      end
      if (ready1) begin
        v1 <= v0;
      end
    end
    if (ready0 && in_valid) begin
      x0 <= in_x;
      y0 <= in_y;
    end
    if (ready1 && v0) begin
      map <= map_next;
    end
  end

  `NV21RAG_ASSERT_IMPL(a_sx_in_frame, v1 && !map.skip, map.sx < eff_w)
  `NV21RAG_ASSERT_IMPL(a_sy_in_frame, v1 && !map.skip, map.sy < eff_h)
  `NV21RAG_ASSERT_NEXT(a_stall_holds_map, v1 && !out_ready, v1 && $stable(map))

endmodule

// ----- design/nv21rag_offset_calc.sv -----
// product stage and sum stage that form the byte offsets, result register
// depends on nv21rag_pkg
module nv21rag_offset_calc (
  input  logic               clk,
  input  logic               rst,
  input  nv21rag_pkg::cfg_t  regs,
  input  logic               in_valid,
  output logic               in_ready,
  input  nv21rag_pkg::map_t  map,
  output logic               out_valid,
  input  logic               out_ready,
  output nv21rag_pkg::res_t  res
);

  typedef struct packed {
    logic [25:0] sy_lrs;
    logic [15:0] sx_lps;
    logic [24:0] y_dw;
    logic [14:0] x_lps;
    logic [25:0] syh_crs;
    logic [22:0] yh_dwh;
    logic [11:0] sxh;
    logic [10:0] xh;
    logic        skip;
    logic        cv;
  } prod_t;

  logic               v2;
  logic               v3;
  logic               ready2;
  logic               ready3;
  prod_t              prod;
  prod_t              prod_next;
  logic [26:0]        sy_lrs_full;
  logic [25:0]        syh_crs_full;
  nv21rag_pkg::res_t  res_next;

  assign ready3    = !v3 || out_ready;
  assign ready2    = !v2 || ready3;
  assign in_ready  = ready2;
  assign out_valid = v3;

  assign sy_lrs_full  = 27'(map.sy) * 27'(regs.luma_row_stride);
  assign syh_crs_full = 26'(map.sy[12:1]) * 26'(regs.chroma_row_stride);

  always_comb begin
    prod_next.sy_lrs  = sy_lrs_full[25:0];
    prod_next.sx_lps  = 16'(map.sx) * 16'(regs.luma_pixel_stride);
    prod_next.y_dw    = 25'(map.y) * 25'(regs.dest_width);
    prod_next.x_lps   = 15'(map.x) * 15'(regs.luma_pixel_stride);
    prod_next.syh_crs = syh_crs_full;
    prod_next.yh_dwh  = 23'(map.y[11:1]) * 23'(regs.dest_width[12:1]);
    prod_next.sxh     = map.sx[12:1];
    prod_next.xh      = map.x[11:1];
    prod_next.skip    = map.skip;
    prod_next.cv      = map.cv;
  end

  // chroma pair stride is two whenever a result is not skipped
  always_comb begin
    res_next = '0;
    res_next.skipped = prod.skip;
    if (!prod.skip) begin
      res_next.src_luma_offset = prod.sy_lrs + 26'(prod.sx_lps);
      res_next.dst_luma_offset = 26'(prod.y_dw) + 26'(prod.x_lps);
      res_next.chroma_valid    = prod.cv;
      if (prod.cv) begin
        res_next.src_chroma_offset = prod.syh_crs + 26'({prod.sxh, 1'b0});
        res_next.dst_chroma_offset = 26'({prod.yh_dwh, 1'b0}) + 26'({prod.xh, 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready2) begin
        v2 <= in_valid;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
    if (ready2 && in_valid) begin
      prod <= prod_next;
    end
    if (ready3 && v2) begin
      res <= res_next;
    end
  end

endmodule

// ----- design/nv21_rotation_address_generator.sv -----
// top level of the nv21 rotation address generator
// depends on nv21rag_pkg, nv21rag_if, nv21rag_cfg_regs, nv21rag_src_map, nv21rag_offset_calc
`include "nv21_rotation_address_generator_assert.svh"

// Takes one destination pixel (dest_col, dest_row) per word and returns the
// source and destination luma byte offsets for a rotation of 0, 90, 180 or
// 270 degrees, plus the chroma pair offsets (V byte at the offset, U byte at
// offset plus one) when both coordinates are even. A new pixel is accepted
// every clock while the result side does not stall; its result passes the
// input register, source mapping register, multiplier register and result
// register. Ready runs combinationally from the result side back to the pixel
// side, so a result stall that meets a full pipe stops input in the same
// cycle. Results carry skipped set and all offsets zero while the chroma pixel
// stride is not 2. Registers are written through the cfg channel, which is
// always ready, and must only be written while no pixel is in flight.
module nv21_rotation_address_generator #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic          clk,
  input  logic          rst,
  nv21rag_pix_if.sink   pixel,
  nv21rag_res_if.source result,
  nv21rag_cfg_if.sink   cfg
);

  nv21rag_pkg::cfg_t  regs;
  nv21rag_pkg::map_t  map;
  nv21rag_pkg::res_t  res;
  logic               map_valid;
  logic               map_ready;

  nv21rag_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  nv21rag_src_map #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_src_map (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .in_x      (pixel.dest_col),
    .in_y      (pixel.dest_row),
    .out_valid (map_valid),
    .out_ready (map_ready),
    .map       (map)
  );

  nv21rag_offset_calc u_offset_calc (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .in_valid  (map_valid),
    .in_ready  (map_ready),
    .map       (map),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res       (res)
  );

  assign result.skipped           = res.skipped;
  assign result.src_luma_offset   = res.src_luma_offset;
  assign result.dst_luma_offset   = res.dst_luma_offset;
  assign result.chroma_valid      = res.chroma_valid;
  assign result.src_chroma_offset = res.src_chroma_offset;
  assign result.dst_chroma_offset = res.dst_chroma_offset;

  `NV21RAG_ASSERT_IMPL(a_skip_zeroes, result.valid && result.skipped,
    !result.chroma_valid && result.src_luma_offset == '0 && result.dst_luma_offset == '0)
  `NV21RAG_ASSERT_IMPL(a_skip_cause, result.valid && result.skipped,
    regs.chroma_pixel_stride != nv21rag_pkg::CHROMA_PAIR_STRIDE)
  `NV21RAG_ASSERT_IMPL(a_odd_no_chroma, result.valid && !result.chroma_valid,
    result.src_chroma_offset == '0 && result.dst_chroma_offset == '0)
  `NV21RAG_ASSERT_IMPL(a_dst_chroma_even, result.valid && result.chroma_valid,
    !result.dst_chroma_offset[0])

endmodule

// ----- tb/nv21_rotation_address_generator_tb.sv -----
// testbench for nv21_rotation_address_generator: drives pixel words with bursty gaps,
// stalls the result side, and checks every address word against a built-in predictor
// depends on nv21rag_pkg, nv21rag_if and the design files
module nv21_rotation_address_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SRC_DIM_MAX = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_SETUPS = 26;
  localparam int WORDS_PER_SETUP = 50;

  class addr_scoreboard;
    nv21rag_pkg::cfg_t regs;
    nv21rag_pkg::res_t pending_addrs[$];
    int mismatches;
    int checked;
    int skipped_seen;
    int chroma_seen;

    function new();
      regs.rotation_quarters   = nv21rag_pkg::ROT_0;
      regs.source_width        = nv21rag_pkg::RESET_DIM;
      regs.source_height       = nv21rag_pkg::RESET_DIM;
      regs.luma_row_stride     = nv21rag_pkg::RESET_ROW_STRIDE;
      regs.luma_pixel_stride   = nv21rag_pkg::RESET_LUMA_PSTR;
      regs.chroma_row_stride   = nv21rag_pkg::RESET_ROW_STRIDE;
      regs.chroma_pixel_stride = nv21rag_pkg::CHROMA_PAIR_STRIDE;
      regs.dest_width          = nv21rag_pkg::RESET_DIM;
      mismatches = 0;
      checked = 0;
      skipped_seen = 0;
      chroma_seen = 0;
    endfunction

    function void set_reg(nv21rag_pkg::cfg_idx_t idx,
                          logic [nv21rag_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        nv21rag_pkg::CFG_ROTATION:
          regs.rotation_quarters = nv21rag_pkg::rot_t'(d[1:0]);
        nv21rag_pkg::CFG_SOURCE_WIDTH:
          regs.source_width = d[nv21rag_pkg::DIM_W-1:0];
        nv21rag_pkg::CFG_SOURCE_HEIGHT:
          regs.source_height = d[nv21rag_pkg::DIM_W-1:0];
        nv21rag_pkg::CFG_LUMA_ROW:
          regs.luma_row_stride = d[nv21rag_pkg::STRIDE_W-1:0];
        nv21rag_pkg::CFG_LUMA_PIXEL:
          regs.luma_pixel_stride = d[nv21rag_pkg::PSTR_W-1:0];
        nv21rag_pkg::CFG_CHROMA_ROW:
          regs.chroma_row_stride = d[nv21rag_pkg::STRIDE_W-1:0];
        nv21rag_pkg::CFG_CHROMA_PIXEL:
          regs.chroma_pixel_stride = d[nv21rag_pkg::PSTR_W-1:0];
        nv21rag_pkg::CFG_DEST_WIDTH:
          regs.dest_width = d[nv21rag_pkg::DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip_dim(logic [nv21rag_pkg::DIM_W-1:0] d);
      if (d == '0) return 64'sd1;
      if (longint'(d) > SRC_DIM_MAX) return SRC_DIM_MAX;
      return longint'(d);
    endfunction

    function nv21rag_pkg::res_t predict_addresses(logic [nv21rag_pkg::COORD_W-1:0] col,
                                                  logic [nv21rag_pkg::COORD_W-1:0] row);
      nv21rag_pkg::res_t r;
      longint cx, cy, w, h, sxs, sys;
      longint unsigned sx, sy, ux, uy, t;
      longint unsigned lrs, lps, crs, cps, dw;
      r = '0;
      if (regs.chroma_pixel_stride != nv21rag_pkg::CHROMA_PAIR_STRIDE) begin
        r.skipped = 1'b1;
        return r;
      end
      cx = longint'(col);
      cy = longint'(row);
      ux = 64'(col);
      uy = 64'(row);
      lrs = 64'(regs.luma_row_stride);
      lps = 64'(regs.luma_pixel_stride);
      crs = 64'(regs.chroma_row_stride);
      cps = 64'(regs.chroma_pixel_stride);
      dw = 64'(regs.dest_width);
      w = clip_dim(regs.source_width);
      h = clip_dim(regs.source_height);
      sxs = cx;
      sys = cy;
      case (regs.rotation_quarters)
        nv21rag_pkg::ROT_90: begin
          sxs = cy;
          sys = h - 1 - cx;
        end
        nv21rag_pkg::ROT_180: begin
          sxs = w - 1 - cx;
          sys = h - 1 - cy;
        end
        nv21rag_pkg::ROT_270: begin
          sxs = w - 1 - cy;
          sys = cx;
        end
        default: ;
      endcase
      sx = (sxs < 0) ? 64'd0 : ((sxs > w - 1) ? 64'(w - 1) : 64'(sxs));
      sy = (sys < 0) ? 64'd0 : ((sys > h - 1) ? 64'(h - 1) : 64'(sys));
      t = sy * lrs + sx * lps;
      r.src_luma_offset = t[nv21rag_pkg::OFF_W-1:0];
      t = uy * dw + ux * lps;
      r.dst_luma_offset = t[nv21rag_pkg::OFF_W-1:0];
      if (!col[0] && !row[0]) begin
        r.chroma_valid = 1'b1;
        t = (sy >> 1) * crs + (sx >> 1) * cps;
        r.src_chroma_offset = t[nv21rag_pkg::OFF_W-1:0];
        t = (uy >> 1) * ((dw >> 1) * cps) + (ux >> 1) * cps;
        r.dst_chroma_offset = t[nv21rag_pkg::OFF_W-1:0];
      end
      return r;
    endfunction

    function void note_pixel(logic [nv21rag_pkg::COORD_W-1:0] col,
                             logic [nv21rag_pkg::COORD_W-1:0] row);
      pending_addrs.push_back(predict_addresses(col, row));
    endfunction

    function void check_result(nv21rag_pkg::res_t got);
      nv21rag_pkg::res_t want;
      if (got.skipped) skipped_seen++;
      if (got.chroma_valid) chroma_seen++;
      if (pending_addrs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] address word with no pixel pending: %p", $realtime, got);
        return;
      end
      want = pending_addrs.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] mismatch on word %0d", $realtime, checked);
          $display("  exp skip=%0b sl=%h dl=%h cv=%0b sc=%h dc=%h", want.skipped,
                   want.src_luma_offset, want.dst_luma_offset, want.chroma_valid,
                   want.src_chroma_offset, want.dst_chroma_offset);
          $display("  got skip=%0b sl=%h dl=%h cv=%0b sc=%h dc=%h", got.skipped,
                   got.src_luma_offset, got.dst_luma_offset, got.chroma_valid,
                   got.src_chroma_offset, got.dst_chroma_offset);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycles = 0;
  int burst_left = 0;
  int setups = 0;
  int words_sent = 0;
  addr_scoreboard sb;

  nv21rag_pix_if pix ();
  nv21rag_res_if res ();
  nv21rag_cfg_if cfg_ch ();

  nv21_rotation_address_generator dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix),
    .result (res),
    .cfg    (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles,
               sb.pending_addrs.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int mode;
    int len;
    int k;
    res.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(16, 80);
      for (k = 0; k < len; k++) begin
        @(negedge clk);
        case (mode)
          0: res.ready <= 1'b1;
          1: res.ready <= 1'($urandom_range(0, 1));
          2: res.ready <= ($urandom_range(0, 3) == 0);
          default: res.ready <= ((k % 11) < 7);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    nv21rag_pkg::res_t got;
    if (!rst && res.valid && res.ready) begin
      got.skipped           = res.skipped;
      got.src_luma_offset   = res.src_luma_offset;
      got.dst_luma_offset   = res.dst_luma_offset;
      got.chroma_valid      = res.chroma_valid;
      got.src_chroma_offset = res.src_chroma_offset;
      got.dst_chroma_offset = res.dst_chroma_offset;
      sb.check_result(got);
    end
  end

  task automatic send_pixel(input logic [nv21rag_pkg::COORD_W-1:0] col,
                            input logic [nv21rag_pkg::COORD_W-1:0] row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        pix.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    pix.valid <= 1'b1;
    pix.dest_col <= col;
    pix.dest_row <= row;
    do @(posedge clk); while (!pix.ready);
    sb.note_pixel(col, row);
    words_sent++;
  endtask

  task automatic write_reg(input nv21rag_pkg::cfg_idx_t idx,
                           input logic [nv21rag_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_setup(input logic [nv21rag_pkg::CFG_DATA_W-1:0] rot, sw, sh, lrs,
                             lps, crs, cps, dw);
    write_reg(nv21rag_pkg::CFG_ROTATION, rot);
    write_reg(nv21rag_pkg::CFG_SOURCE_WIDTH, sw);
    write_reg(nv21rag_pkg::CFG_SOURCE_HEIGHT, sh);
    write_reg(nv21rag_pkg::CFG_LUMA_ROW, lrs);
    write_reg(nv21rag_pkg::CFG_LUMA_PIXEL, lps);
    write_reg(nv21rag_pkg::CFG_CHROMA_ROW, crs);
    write_reg(nv21rag_pkg::CFG_CHROMA_PIXEL, cps);
    write_reg(nv21rag_pkg::CFG_DEST_WIDTH, dw);
    setups++;
  endtask

  // drain the pipe before touching registers or ending
  task automatic wait_idle();
    @(negedge clk);
    pix.valid <= 1'b0;
    while (sb.pending_addrs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [nv21rag_pkg::CFG_DATA_W-1:0] pick_dim();
    logic [nv21rag_pkg::CFG_DATA_W-1:0] d;
    case ($urandom_range(0, 9))
      0: d = 14'd0;
      1: d = 14'd4096;
      2: d = 14'($urandom_range(4097, 8191));
      3: d = 14'd1;
      4: d = 14'($urandom_range(65, 4095));
      default: d = 14'($urandom_range(1, 64));
    endcase
    d[nv21rag_pkg::CFG_DATA_W-1] = 1'($urandom_range(0, 1));
    return d;
  endfunction

  function automatic logic [nv21rag_pkg::CFG_DATA_W-1:0] pick_row_stride();
    case ($urandom_range(0, 5))
      0: return 14'd0;
      1: return 14'd1;
      2: return 14'd16383;
      default: return 14'($urandom_range(0, 16383));
    endcase
  endfunction

  initial begin
    logic [nv21rag_pkg::CFG_DATA_W-1:0] cps;
    logic [nv21rag_pkg::COORD_W-1:0] col, row;
    longint span;
    int ph;
    pix.valid = 1'b0;
    pix.dest_col = '0;
    pix.dest_row = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, plain copy: corners and parity mixes
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd1, 12'd2);
    send_pixel(12'd2, 12'd1);
    send_pixel(12'd3, 12'd3);
    send_pixel(12'hAAA, 12'h555);

    // quarter turn, width 0 and oversize height, max strides, offsets wrap
    wait_idle();
    write_setup(14'(nv21rag_pkg::ROT_90), 14'h2000, 14'h3FFF, 14'd16383, 14'd7,
                14'd16383, 14'(nv21rag_pkg::CHROMA_PAIR_STRIDE), 14'h1FFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4094, 12'd4094);
    send_pixel(12'd1, 12'd0);

    // half turn, minimum height and strides, coordinates far outside the frame
    wait_idle();
    write_setup(14'(nv21rag_pkg::ROT_180), 14'd4096, 14'd1, 14'd1, 14'd1, 14'd1,
                14'(nv21rag_pkg::CHROMA_PAIR_STRIDE), 14'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd2);
    send_pixel(12'd2, 12'd4095);

    // three quarters, chroma pixel stride zero gives skipped words
    wait_idle();
    write_setup(14'(nv21rag_pkg::ROT_270), 14'd5000, 14'd3, 14'd100, 14'd0, 14'd0,
                14'h3FF8, 14'd640);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd5, 12'd7);

    // stride with the pair bit set but others too
    wait_idle();
    write_reg(nv21rag_pkg::CFG_CHROMA_PIXEL, 14'd6);
    send_pixel(12'd2, 12'd4);
    send_pixel(12'd9, 12'd4094);

    for (ph = 0; ph < RANDOM_SETUPS; ph++) begin
      wait_idle();
      cps = 14'($urandom);
      if ($urandom_range(0, 6) != 0)
        cps[nv21rag_pkg::PSTR_W-1:0] = nv21rag_pkg::CHROMA_PAIR_STRIDE;
      write_setup(14'($urandom), pick_dim(), pick_dim(), pick_row_stride(),
                  14'($urandom), pick_row_stride(), cps, pick_dim());
      span = sb.clip_dim(sb.regs.source_width);
      if (sb.clip_dim(sb.regs.source_height) > span)
        span = sb.clip_dim(sb.regs.source_height);
      span = (span + 1 > 4095) ? 64'sd4095 : span + 1;
      repeat (WORDS_PER_SETUP) begin
        if ($urandom_range(0, 9) < 6) begin
          col = 12'($urandom);
          row = 12'($urandom);
        end else begin
          col = 12'($urandom_range(0, 32'(span)));
          row = 12'($urandom_range(0, 32'(span)));
        end
        send_pixel(col, row);
      end
    end

    wait_idle();
    $display("sent %0d pixel words over %0d register setups, checked %0d", words_sent,
             setups, sb.checked);
    $display("%0d words skipped, %0d carried chroma offsets, %0d mismatches",
             sb.skipped_seen, sb.chroma_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_addrs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
